// File: hw/rtl/inm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package inm_pkg;

  localparam int unsigned LANES_DEFAULT = 4;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned ACC_W         = 32;
  localparam int unsigned ACT_OUT_W     = 7;
  localparam int unsigned SHIFT_W       = 5;
  localparam int unsigned ACT_MAX       = 127;
  localparam int unsigned SHIFT_RESET   = 8;

  // request control travelling alongside the payload of a stage
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/inm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module inm_lane (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [inm_pkg::DATA_W-1:0]   act_i,
  input  wire logic signed [inm_pkg::DATA_W-1:0]   wt_i,
  output logic signed      [inm_pkg::PROD_W-1:0]   prod_o
);

  logic signed [inm_pkg::PROD_W-1:0] prod_d;
  logic signed [inm_pkg::PROD_W-1:0] prod_q;

  assign prod_d = act_i * wt_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: hw/rtl/inm_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module inm_merge #(
  parameter int unsigned LANES = inm_pkg::LANES_DEFAULT
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         en_i,
  input  wire inm_pkg::pipe_ctl_t                           ctl_i,
  input  wire logic signed [inm_pkg::ACC_W-1:0]             bias_i,
  input  wire logic signed [inm_pkg::PROD_W-1:0]            prod_i [LANES],
  output inm_pkg::pipe_ctl_t                                ctl_o,
  output logic signed      [inm_pkg::ACC_W-1:0]             bias_o,
  output logic signed      [inm_pkg::PROD_W+$clog2(LANES)-1:0] psum_o
);

  localparam int unsigned LVLS   = $clog2(LANES);
  localparam int unsigned PAD    = 2 ** LVLS;
  localparam int unsigned PSUM_W = inm_pkg::PROD_W + LVLS;

  logic signed [PSUM_W-1:0] tree [LVLS+1][PAD];
  logic signed [PSUM_W-1:0] psum_q;
  inm_pkg::pipe_ctl_t       ctl_q;
  logic signed [inm_pkg::ACC_W-1:0] bias_q;

  // pairwise adder tree, one level per pass, lanes padded to a power of two
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < PAD; i++) begin
        tree[l][i] = '0;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      tree[0][i] = PSUM_W'(prod_i[i]);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (PAD >> (l + 1)); i++) begin
        tree[l+1][i] = tree[l][2*i] + tree[l][2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid) begin
      psum_q <= tree[LVLS][0];
      bias_q <= bias_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign bias_o = bias_q;
  assign psum_o = psum_q;

endmodule

`default_nettype wire

// File: hw/rtl/inm_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module inm_accum #(
  parameter int unsigned PSUM_W = inm_pkg::PROD_W + 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire inm_pkg::pipe_ctl_t                  ctl_i,
  input  wire logic signed [PSUM_W-1:0]            psum_i,
  input  wire logic signed [inm_pkg::ACC_W-1:0]    bias_i,
  output logic                                     valid_o,
  output logic signed      [inm_pkg::ACC_W-1:0]    bsum_o
);

  logic signed [inm_pkg::ACC_W-1:0] acc_q;
  logic signed [inm_pkg::ACC_W-1:0] acc_d;
  logic signed [inm_pkg::ACC_W-1:0] bsum_q;
  logic signed [inm_pkg::ACC_W-1:0] bsum_d;
  logic                             valid_q;
  logic                             take;

  assign take   = en_i && ctl_i.valid;
  assign acc_d  = acc_q + inm_pkg::ACC_W'(psum_i);
  assign bsum_d = acc_d + bias_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (en_i) begin
        valid_q <= ctl_i.valid && ctl_i.last;
      end
      if (take) begin
        acc_q <= ctl_i.last ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctl_i.last) begin
      bsum_q <= bsum_d;
    end
  end

  assign valid_o = valid_q;
  assign bsum_o  = bsum_q;

  // neuron ends: accumulator restarts from zero
  a_acc_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctl_i.last |=> acc_q == '0)
    else $error("accumulator not cleared after last patch");

  a_acc_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(acc_q))
    else $error("accumulator moved without a request");

  a_acc_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !ctl_i.last |=> acc_q == $past(acc_d))
    else $error("accumulator update wrong");

endmodule

`default_nettype wire

// File: hw/rtl/inm_requant.sv
`timescale 1ns / 1ps
`default_nettype none

module inm_requant (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  input  wire logic signed [inm_pkg::ACC_W-1:0]       bsum_i,
  input  wire logic        [inm_pkg::SHIFT_W-1:0]     shift_i,
  input  wire logic                                   ready_i,
  output logic                                        en_o,
  output logic                                        valid_o,
  output logic             [inm_pkg::ACT_OUT_W-1:0]   act_o,
  output logic signed      [inm_pkg::ACC_W-1:0]       bsum_o
);

  localparam int unsigned MAG_W = inm_pkg::ACC_W - 1;

  logic [MAG_W-1:0]                 shifted;
  logic [inm_pkg::ACT_OUT_W-1:0]    act_d;
  logic [inm_pkg::ACT_OUT_W-1:0]    act_q;
  logic signed [inm_pkg::ACC_W-1:0] bsum_q;
  logic                             valid_q;
  logic                             en;

  assign en      = !valid_q || ready_i;
  // ReLU leaves a non-negative value, so the shift is logical
  assign shifted = bsum_i[MAG_W-1:0] >> shift_i;

  always_comb begin
    if (bsum_i[inm_pkg::ACC_W-1]) begin
      act_d = '0;
    end else if (shifted > MAG_W'(inm_pkg::ACT_MAX)) begin
      act_d = inm_pkg::ACT_OUT_W'(inm_pkg::ACT_MAX);
    end else begin
      act_d = shifted[inm_pkg::ACT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      act_q  <= act_d;
      bsum_q <= bsum_i;
    end
  end

  assign en_o    = en;
  assign valid_o = valid_q;
  assign act_o   = act_q;
  assign bsum_o  = bsum_q;

  a_relu_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && bsum_q[inm_pkg::ACC_W-1] |-> act_q == '0)
    else $error("negative sum gave a non-zero activation");

endmodule

`default_nettype wire

// File: hw/rtl/int8_neuron_mac_relu_requant_unit.sv
// Channel   | Dir | Payload
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | tdata: act_0..act_N-1, wt_0..wt_N-1, bias; tlast: last_patch
// m_axis    | out | tdata: activation, biased_sum, zero pad
// cfg       | in  | cfg_we_i / cfg_wdata_i: shift_amount
//
// One patch accepted per cycle while s_axis_tready is high; m_axis_tvalid rises once
// the last patch of a neuron has passed the lane, merge, accumulator and requant registers.
// Stages: lane multipliers, adder tree, accumulator, ReLU/shift/clamp register.
// Reset: shift_amount = 8, accumulator = 0, all stages empty.
// Each stage drains on its own, so s_axis stalls only once all four stage
// registers hold requests and m_axis is not ready.
`timescale 1ns / 1ps
`default_nettype none

module int8_neuron_mac_relu_requant_unit #(
  parameter int unsigned LANES = inm_pkg::LANES_DEFAULT
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // act_0..act_N-1, wt_0..wt_N-1, bias
  input  wire logic [2*LANES*inm_pkg::DATA_W+inm_pkg::ACC_W-1:0] s_axis_tdata,
  input  wire logic                                      s_axis_tlast,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // activation, biased_sum, zero pad
  output logic [39:0]                                    m_axis_tdata,
  input  wire logic                                      cfg_we_i,
  input  wire logic [inm_pkg::SHIFT_W-1:0]               cfg_wdata_i
);

  localparam int unsigned PSUM_W = inm_pkg::PROD_W + $clog2(LANES);
  localparam int unsigned BIAS_LO = 2 * LANES * inm_pkg::DATA_W;

  logic [inm_pkg::SHIFT_W-1:0]        shift_q;
  logic                               en1, en2, en3, en_out;
  inm_pkg::pipe_ctl_t                 ctl1_q, ctl1_d, ctl2;
  logic signed [inm_pkg::ACC_W-1:0]   bias1_q, bias2;
  logic signed [inm_pkg::PROD_W-1:0]  prod [LANES];
  logic signed [PSUM_W-1:0]           psum;
  logic                               v3;
  logic signed [inm_pkg::ACC_W-1:0]   bsum3;
  logic                               out_valid;
  logic [inm_pkg::ACT_OUT_W-1:0]      out_act;
  logic signed [inm_pkg::ACC_W-1:0]   out_bsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= inm_pkg::SHIFT_W'(inm_pkg::SHIFT_RESET);
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  assign en3 = !v3 || en_out;
  assign en2 = !ctl2.valid || en3;
  assign en1 = !ctl1_q.valid || en2;
  assign s_axis_tready = en1;

  assign ctl1_d.valid = s_axis_tvalid;
  assign ctl1_d.last  = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en1) begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      bias1_q <= s_axis_tdata[BIAS_LO +: inm_pkg::ACC_W];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    inm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en1 && s_axis_tvalid),
      .act_i  (s_axis_tdata[g*inm_pkg::DATA_W +: inm_pkg::DATA_W]),
      .wt_i   (s_axis_tdata[(LANES+g)*inm_pkg::DATA_W +: inm_pkg::DATA_W]),
      .prod_o (prod[g])
    );
  end

  inm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en2),
    .ctl_i  (ctl1_q),
    .bias_i (bias1_q),
    .prod_i (prod),
    .ctl_o  (ctl2),
    .bias_o (bias2),
    .psum_o (psum)
  );

  inm_accum #(
    .PSUM_W (PSUM_W)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .ctl_i   (ctl2),
    .psum_i  (psum),
    .bias_i  (bias2),
    .valid_o (v3),
    .bsum_o  (bsum3)
  );

  inm_requant u_requant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .bsum_i  (bsum3),
    .shift_i (shift_q),
    .ready_i (m_axis_tready),
    .en_o    (en_out),
    .valid_o (out_valid),
    .act_o   (out_act),
    .bsum_o  (out_bsum)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_bsum, out_act};

  // input back-pressure only when the whole pipe is full and blocked
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ctl1_q.valid && ctl2.valid && v3 && out_valid && !m_axis_tready)
    else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire
